[sv/clnorm_pkg.sv]
// Package for the channel L2 normalizer: widths, counts, the sequencer states
// and the result type of the shared subtract/compare unit. No dependencies.
`default_nettype none

package clnorm_pkg;

    localparam int MAX_CHANNELS = 64;
    localparam int ADDR_W       = $clog2(MAX_CHANNELS);
    localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
    localparam int SAMPLE_W     = 16;
    localparam int SUM_W        = 37;
    localparam int FRAC_EXTRA   = 16;                        // square sum is shifted up by this
    localparam int RAD_W        = SUM_W + FRAC_EXTRA + 1;    // even width for 2-bit digits
    localparam int ROOT_W       = RAD_W / 2;                 // 27 result bits
    localparam int SQRT_STEPS   = ROOT_W;
    localparam int QUO_W        = 16;
    localparam int DIV_STEPS    = QUO_W;
    localparam int PRE_SHIFT    = 22 - QUO_W;                // sample scale left before divide
    localparam int ALU_W        = 30;
    localparam int STEP_W       = 5;
    localparam logic [QUO_W-1:0] Q114_ONE = 16'd16384;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_READ,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             ge;
        logic [ALU_W-1:0] diff;
    } alu_res_t;

endpackage

`default_nettype wire

[sv/clnorm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none

module clnorm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/clnorm_alu.sv]
// Shared subtract/compare unit used by the square root and the divider.
// Depends on clnorm_pkg.
`default_nettype none

module clnorm_alu
    import clnorm_pkg::*;
(
    input  wire logic [ALU_W-1:0] op_a,
    input  wire logic [ALU_W-1:0] op_b,
    output alu_res_t              res
);

    logic [ALU_W:0] wide_diff;

    assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
    assign res.ge    = ~wide_diff[ALU_W];
    assign res.diff  = wide_diff[ALU_W-1:0];

endmodule

`default_nettype wire

[sv/channel_l2_normalize.sv]
// Top level of the channel L2 normalizer: input accumulation, sequencer,
// square root and divider steps. Depends on clnorm_pkg, clnorm_ram, clnorm_alu.
`default_nettype none

// Samples of one pixel vector enter on the s_ side, one transaction each, in
// channel order; each is stored and its square added to a running sum, so the
// input side takes one sample per cycle while a vector fills. The transaction
// that completes the vector (channel_count samples, clamped to 1..64) starts
// the result phase and s_tready drops until its last result is in the output
// register. The norm is the floor square root of the sum scaled by 2^16,
// found one root bit per radicand bit pair on one 30-bit subtract/compare
// unit (skipped for an all-zero vector). Each result then takes a RAM read,
// a range check, 16 restoring divide steps on the same unit and an output
// step; the divide steps are skipped when the quotient saturates or the
// vector is all zero. Results leave on the m_ side: tdata is the Q1.14
// quotient, tlast marks the vector's final result and tuser flags an
// all-zero vector (its results read 0). channel_count is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is
// idle, which the block itself does not enforce.

module channel_l2_normalize
    import clnorm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data,   // channel_count
    // sample stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,       // [15:0] sample
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,       // [15:0] normalized
    output logic             m_tlast,       // last_of_vector
    output logic             m_tuser        // [0] zero_norm
);

    // control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   chan_cfg_reg;
    logic [CNT_W-1:0]   rcv_cnt_reg, rcv_cnt_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               m_valid_reg, m_valid_next;

    // payload and working registers
    logic [RAD_W-1:0]   rad_reg, rad_next;
    logic [ALU_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic               zero_reg, zero_next;
    logic               sat_reg, sat_next;
    logic               neg_reg, neg_next;
    logic [15:0]        m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;
    logic               m_user_reg, m_user_next;

    // input side
    logic                in_fire;
    logic [SAMPLE_W-1:0] in_mag;
    logic [2*SAMPLE_W-1:0] in_sq;
    logic [SUM_W-1:0]    sum_acc;
    logic [CNT_W-1:0]    cnt_inc;
    logic [CNT_W-1:0]    eff_count;
    logic                vec_done;

    // stored sample read back
    logic [SAMPLE_W-1:0] rd_sample;
    logic [SAMPLE_W-1:0] rd_mag;
    logic                rd_en;

    // shared unit
    logic [ALU_W-1:0]    alu_a, alu_b;
    alu_res_t            alu_res;

    // result shaping
    logic [QUO_W-1:0]    res_mag;
    logic                out_free;
    logic                is_last;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid & s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    assign in_mag  = s_tdata[SAMPLE_W-1] ? (~s_tdata + 1'b1) : s_tdata;
    assign in_sq   = in_mag * in_mag;
    assign sum_acc = sum_reg + {{(SUM_W - 2*SAMPLE_W){1'b0}}, in_sq};
    assign cnt_inc = rcv_cnt_reg + 1'b1;

    // clamp channel_count into 1..MAX_CHANNELS
    always_comb
    begin
        if (chan_cfg_reg == '0)
        begin
            eff_count = CNT_W'(1);
        end
        else if (chan_cfg_reg > CNT_W'(MAX_CHANNELS))
        begin
            eff_count = CNT_W'(MAX_CHANNELS);
        end
        else
        begin
            eff_count = chan_cfg_reg;
        end
    end

    assign vec_done = (cnt_inc >= eff_count) || (cnt_inc == CNT_W'(MAX_CHANNELS));

    assign rd_en  = (state_reg == ST_READ);
    assign rd_mag = rd_sample[SAMPLE_W-1] ? (~rd_sample + 1'b1) : rd_sample;

    clnorm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_CHANNELS)
    ) u_store (
        .clk     (clk),
        .wr_en   (in_fire),
        .wr_addr (rcv_cnt_reg[ADDR_W-1:0]),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_sample)
    );

    // Operand select for the shared unit:
    //   square root: bring down two radicand bits, trial = root*4 + 1
    //   range check: sample magnitude * 2^6 against the norm
    //   divide step: remainder * 2 against the norm
    always_comb
    begin
        alu_a = '0;
        alu_b = {{(ALU_W - ROOT_W){1'b0}}, root_reg};
        case (state_reg)
            ST_SQRT:
            begin
                alu_a = {rem_reg[ALU_W-3:0], rad_reg[RAD_W-1 -: 2]};
                alu_b = {{(ALU_W - ROOT_W - 2){1'b0}}, root_reg, 2'b01};
            end
            ST_CHECK:
            begin
                alu_a = {{(ALU_W - SAMPLE_W - PRE_SHIFT){1'b0}}, rd_mag, {PRE_SHIFT{1'b0}}};
            end
            ST_DIV:
            begin
                alu_a = {rem_reg[ALU_W-2:0], 1'b0};
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    clnorm_alu u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .res  (alu_res)
    );

    // Clamp the quotient to 1.0 (zero for an all-zero vector); the sample's sign is applied in ST_OUT.
    always_comb
    begin
        if (zero_reg)
        begin
            res_mag = '0;
        end
        else if (sat_reg || (quo_reg > Q114_ONE))
        begin
            res_mag = Q114_ONE;
        end
        else
        begin
            res_mag = quo_reg;
        end
    end

    assign out_free = ~m_valid_reg | m_tready;
    assign is_last  = ({1'b0, idx_reg} + 1'b1) == len_reg;

    always_comb
    begin
        state_next   = state_reg;
        rcv_cnt_next = rcv_cnt_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        rad_next     = rad_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        quo_next     = quo_reg;
        step_next    = step_reg;
        idx_next     = idx_reg;
        len_next     = len_reg;
        zero_next    = zero_reg;
        sat_next     = sat_reg;
        neg_next     = neg_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (vec_done)
                    begin
                        // vector complete: clear the accumulator, start the root (or the reads for a zero sum)
                        rcv_cnt_next = '0;
                        sum_next     = '0;
                        len_next     = cnt_inc;
                        idx_next     = '0;
                        zero_next    = (sum_acc == '0);
                        rad_next     = {1'b0, sum_acc, {FRAC_EXTRA{1'b0}}};
                        rem_next     = '0;
                        root_next    = '0;
                        step_next    = '0;
                        state_next   = (sum_acc == '0) ? ST_READ : ST_SQRT;
                    end
                    else
                    begin
                        rcv_cnt_next = cnt_inc;
                        sum_next     = sum_acc;
                    end
                end
            end

            ST_SQRT:
            begin
                rad_next = {rad_reg[RAD_W-3:0], 2'b00};
                if (alu_res.ge)
                begin
                    rem_next  = alu_res.diff;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = alu_a;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                neg_next  = rd_sample[SAMPLE_W-1];
                quo_next  = '0;
                sat_next  = 1'b0;
                step_next = '0;
                rem_next  = alu_a;
                if (zero_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (alu_res.ge)
                begin
                    // quotient would not fit the divider: saturate
                    sat_next   = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (alu_res.ge)
                begin
                    rem_next = alu_res.diff;
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = alu_a;
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = neg_reg ? (16'd0 - res_mag) : res_mag;
                    m_last_next  = is_last;
                    m_user_next  = zero_reg;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            chan_cfg_reg <= CNT_W'(MAX_CHANNELS);
            rcv_cnt_reg  <= '0;
            sum_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rcv_cnt_reg  <= rcv_cnt_next;
            sum_reg      <= sum_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en)
            begin
                chan_cfg_reg <= cfg_wr_data;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        rad_reg    <= rad_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        idx_reg    <= idx_next;
        len_reg    <= len_next;
        zero_reg   <= zero_next;
        sat_reg    <= sat_next;
        neg_reg    <= neg_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

endmodule

`default_nettype wire

[sv/clnorm_checker.sv]
// Port-level checks for channel_l2_normalize and the bind that attaches them.
// Depends only on the top level's ports.
`default_nettype none

module clnorm_port_checks (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

    // a zero-norm vector yields zero results
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 16'd0)
        else $error("zero-norm result not zero");

    // results stay within plus or minus one in Q1.14
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata) <= 16'sd16384) && ($signed(m_tdata) >= -16'sd16384))
        else $error("result out of range");

    // no new sample is taken while a vector still has results to produce
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a vector's results");

endmodule

bind channel_l2_normalize clnorm_port_checks u_clnorm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
